### src/bpt_pkg.sv
// ============================================================================
// bpt_pkg: shared types and constants of the pressure/temperature compensation
// Field widths, intermediate widths, fixed shift amounts, correction factors,
// register indexes and the structs that pass between the pipeline sections.
// ============================================================================
package bpt_pkg;

    // Port field widths.
    localparam int W_RAW     = 24;
    localparam int W_COEF    = 16;
    localparam int W_TEMP    = 20;
    localparam int W_PRES    = 32;
    localparam int W_CFG_IDX = 3;

    // Pipeline organization: three sections of three stages each.
    localparam int NUM_STAGES = 9;
    localparam int STG_FRONT  = 0;
    localparam int STG_CORR   = 3;
    localparam int STG_PRESS  = 6;

    // Intermediate widths, sized from the value ranges of the datasheet form.
    localparam int W_DT    = 25;                 // D2 - C5*2^8
    localparam int W_PROD1 = W_DT + W_COEF + 1;  // dT times a coefficient
    localparam int W_DD    = 48;                 // dT squared, non-negative
    localparam int W_A     = 18;                 // TEMP - 2000 before T2
    localparam int W_B     = 19;                 // TEMP + 1500 before T2
    localparam int W_T2    = 17;
    localparam int W_P4S   = 35;                 // C4*dT >> 6
    localparam int W_P3S   = 34;                 // C3*dT >> 7
    localparam int W_OFF1  = 36;
    localparam int W_SENS1 = 35;
    localparam int W_SQ    = 35;                 // squares of A and B
    localparam int W_M61   = 40;
    localparam int W_OFF2  = 39;
    localparam int W_SENS2 = 38;
    localparam int W_OFF   = 41;
    localparam int W_SENS  = 40;
    localparam int W_SPLIT = 20;                 // low half of SENS for the multiply
    localparam int W_PL    = W_RAW + W_SPLIT;
    localparam int W_PH    = W_RAW + W_SENS - W_SPLIT + 1;
    localparam int W_PROD  = 64;
    localparam int W_Q     = 44;

    // Shift amounts.
    localparam int C5_SCALE_SH = 8;
    localparam int C2_SCALE_SH = 17;
    localparam int C1_SCALE_SH = 16;
    localparam int TEMP_SHIFT  = 23;
    localparam int OFF_SHIFT   = 6;
    localparam int SENS_SHIFT  = 7;
    localparam int T2_SHIFT    = 31;
    localparam int OFF2_A_SH   = 4;
    localparam int PROD_SHIFT  = 21;
    localparam int P_SHIFT     = 15;

    // Second-order correction factors and temperature thresholds.
    localparam int OFF2_A_MUL  = 61;
    localparam int OFF2_B_MUL  = 15;
    localparam int SENS2_A_MUL = 2;
    localparam int SENS2_B_MUL = 8;
    localparam int TEMP_BASE   = 2000;
    localparam int B_OFFSET    = 3500;   // from TEMP-2000 to TEMP+1500

    localparam logic signed [W_TEMP-1:0] TEMP_SAT_LO = W_TEMP'(-300000);
    localparam logic signed [W_TEMP-1:0] TEMP_SAT_HI = W_TEMP'(150000);

    typedef enum logic [W_CFG_IDX-1:0] {
        REG_C1 = 3'd0,
        REG_C2 = 3'd1,
        REG_C3 = 3'd2,
        REG_C4 = 3'd3,
        REG_C5 = 3'd4,
        REG_C6 = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [W_COEF-1:0] c1;
        logic [W_COEF-1:0] c2;
        logic [W_COEF-1:0] c3;
        logic [W_COEF-1:0] c4;
        logic [W_COEF-1:0] c5;
        logic [W_COEF-1:0] c6;
    } t_coef;

    // Load enables of the three stages of one section.
    typedef struct packed {
        logic s0;
        logic s1;
        logic s2;
    } t_stg_en;

    typedef struct packed {
        logic signed [W_A-1:0]     a;
        logic signed [W_B-1:0]     b;
        logic        [W_T2-1:0]    t2;
        logic signed [W_OFF1-1:0]  off;
        logic signed [W_SENS1-1:0] sens;
        logic        [W_RAW-1:0]   d1;
    } t_front;

    typedef struct packed {
        logic signed [W_TEMP-1:0] temp;
        logic signed [W_OFF-1:0]  off;
        logic signed [W_SENS-1:0] sens;
        logic        [W_RAW-1:0]  d1;
    } t_corr;

endpackage

### src/baro_pressure_temp_compensation.sv
// ============================================================================
// baro_pressure_temp_compensation: barometric sensor compensation pipeline
// Raw pressure and temperature words in, compensated temperature (0.01 C)
// and pressure (Pa) out, with second-order correction at low temperature.
//
//   channel   direction   handshake                  payload
//   input     in          i_in_valid / o_in_stall    i_raw_pressure, i_raw_temperature
//   output    out         o_out_valid / i_out_stall  o_temp_centi_c, o_pressure_pa
//   config    in          i_cfg_we                   i_cfg_idx, i_cfg_data
//
// One word is accepted per cycle while the input is not stalled; each result
// passes through the nine-stage datapath (four parallel dT products,
// two squares, and D1*SENS split into two partial products).
// Reset clears the stage valid bits and all six coefficients to zero.
// An output stall holds the last stage; earlier stages keep filling empty
// slots, so the input stalls only when every stage holds a word.
// ============================================================================
module baro_pressure_temp_compensation import bpt_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [W_RAW-1:0]         i_raw_pressure,
    input  logic [W_RAW-1:0]         i_raw_temperature,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [W_TEMP-1:0] o_temp_centi_c,
    output logic signed [W_PRES-1:0] o_pressure_pa,
    input  logic                     i_cfg_we,
    input  logic [W_CFG_IDX-1:0]     i_cfg_idx,
    input  logic [W_COEF-1:0]        i_cfg_data
);

    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] w_en;
    t_coef                 w_coef;
    t_front                w_front;
    t_corr                 w_corr;
    t_stg_en               w_en_front;
    t_stg_en               w_en_corr;
    t_stg_en               w_en_press;

    // A stage loads when it is empty or when the stage after it moves on.
    always_comb begin
        w_en[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || !i_out_stall;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign w_en_front = '{s0: w_en[STG_FRONT], s1: w_en[STG_FRONT+1], s2: w_en[STG_FRONT+2]};
    assign w_en_corr  = '{s0: w_en[STG_CORR],  s1: w_en[STG_CORR+1],  s2: w_en[STG_CORR+2]};
    assign w_en_press = '{s0: w_en[STG_PRESS], s1: w_en[STG_PRESS+1], s2: w_en[STG_PRESS+2]};

    bpt_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_coef     (w_coef)
    );

    bpt_front u_front (
        .i_clk  (i_clk),
        .i_en   (w_en_front),
        .i_coef (w_coef),
        .i_d1   (i_raw_pressure),
        .i_d2   (i_raw_temperature),
        .o_res  (w_front)
    );

    bpt_corr u_corr (
        .i_clk   (i_clk),
        .i_en    (w_en_corr),
        .i_front (w_front),
        .o_res   (w_corr)
    );

    bpt_press u_press (
        .i_clk  (i_clk),
        .i_en   (w_en_press),
        .i_corr (w_corr),
        .o_temp (o_temp_centi_c),
        .o_pres (o_pressure_pa)
    );

    assign o_in_stall  = !w_en[0];
    assign o_out_valid = r_vld[NUM_STAGES-1];

endmodule

### src/bpt_cfg.sv
// ============================================================================
// bpt_cfg: calibration coefficient registers
// Six 16-bit words written through a plain indexed write port.
// ============================================================================
module bpt_cfg import bpt_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [W_CFG_IDX-1:0] i_cfg_idx,
    input  logic [W_COEF-1:0]    i_cfg_data,
    output t_coef                o_coef
);

    t_coef r_coef;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                REG_C1:  r_coef.c1 <= i_cfg_data;
                REG_C2:  r_coef.c2 <= i_cfg_data;
                REG_C3:  r_coef.c3 <= i_cfg_data;
                REG_C4:  r_coef.c4 <= i_cfg_data;
                REG_C5:  r_coef.c5 <= i_cfg_data;
                REG_C6:  r_coef.c6 <= i_cfg_data;
                default: r_coef <= r_coef;
            endcase
        end
    end

    assign o_coef = r_coef;

endmodule

### src/bpt_front.sv
// ============================================================================
// bpt_front: first-order terms
// Stages 1-3: temperature difference, the four products with dT, then the
// first-order offset, sensitivity, T2 and the temperature distances A and B.
// ============================================================================
module bpt_front import bpt_pkg::*; (
    input  logic             i_clk,
    input  t_stg_en          i_en,
    input  t_coef            i_coef,
    input  logic [W_RAW-1:0] i_d1,
    input  logic [W_RAW-1:0] i_d2,
    output t_front           o_res
);

    // Stage 1: dT = D2 - C5*2^8
    logic signed [W_DT-1:0]  n_s1_dt;
    logic signed [W_DT-1:0]  r_s1_dt;
    logic        [W_RAW-1:0] r_s1_d1;

    assign n_s1_dt = $signed({1'b0, i_d2})
                   - $signed({1'b0, i_coef.c5, {C5_SCALE_SH{1'b0}}});

    always_ff @(posedge i_clk) begin
        if (i_en.s0) begin
            r_s1_dt <= n_s1_dt;
            r_s1_d1 <= i_d1;
        end
    end

    // Stage 2: products with dT
    logic signed [W_COEF:0]    w_c3s;
    logic signed [W_COEF:0]    w_c4s;
    logic signed [W_COEF:0]    w_c6s;
    logic signed [W_PROD1-1:0] n_s2_p3;
    logic signed [W_PROD1-1:0] n_s2_p4;
    logic signed [W_PROD1-1:0] n_s2_p6;
    logic signed [2*W_DT-1:0]  n_s2_dd;
    logic signed [W_PROD1-1:0] r_s2_p3;
    logic signed [W_PROD1-1:0] r_s2_p4;
    logic signed [W_PROD1-1:0] r_s2_p6;
    logic        [W_DD-1:0]    r_s2_dd;
    logic        [W_RAW-1:0]   r_s2_d1;

    assign w_c3s   = $signed({1'b0, i_coef.c3});
    assign w_c4s   = $signed({1'b0, i_coef.c4});
    assign w_c6s   = $signed({1'b0, i_coef.c6});
    assign n_s2_p3 = W_PROD1'(r_s1_dt) * W_PROD1'(w_c3s);
    assign n_s2_p4 = W_PROD1'(r_s1_dt) * W_PROD1'(w_c4s);
    assign n_s2_p6 = W_PROD1'(r_s1_dt) * W_PROD1'(w_c6s);
    assign n_s2_dd = (2*W_DT)'(r_s1_dt) * (2*W_DT)'(r_s1_dt);

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_s2_p3 <= n_s2_p3;
            r_s2_p4 <= n_s2_p4;
            r_s2_p6 <= n_s2_p6;
            r_s2_dd <= n_s2_dd[W_DD-1:0];
            r_s2_d1 <= r_s1_d1;
        end
    end

    // Stage 3: the part-selects are the arithmetic shifts, since every
    // product fits in one bit less than its declared width.
    logic signed [W_A-1:0]     w_a;
    logic signed [W_P4S-1:0]   w_p4s;
    logic signed [W_P3S-1:0]   w_p3s;
    t_front                    n_s3;
    t_front                    r_s3;

    assign w_a   = $signed(r_s2_p6[W_A+TEMP_SHIFT-1:TEMP_SHIFT]);
    assign w_p4s = $signed(r_s2_p4[W_P4S+OFF_SHIFT-1:OFF_SHIFT]);
    assign w_p3s = $signed(r_s2_p3[W_P3S+SENS_SHIFT-1:SENS_SHIFT]);

    always_comb begin
        n_s3.a    = w_a;
        n_s3.b    = W_B'(w_a) + W_B'(B_OFFSET);
        n_s3.t2   = r_s2_dd[W_DD-1:T2_SHIFT];
        n_s3.off  = $signed({{(W_OFF1-W_COEF-C2_SCALE_SH){1'b0}}, i_coef.c2,
                             {C2_SCALE_SH{1'b0}}}) + W_OFF1'(w_p4s);
        n_s3.sens = $signed({{(W_SENS1-W_COEF-C1_SCALE_SH){1'b0}}, i_coef.c1,
                             {C1_SCALE_SH{1'b0}}}) + W_SENS1'(w_p3s);
        n_s3.d1   = r_s2_d1;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_s3 <= n_s3;
        end
    end

    assign o_res = r_s3;

endmodule

### src/bpt_corr.sv
// ============================================================================
// bpt_corr: second-order correction
// Stages 4-6: squares of A and B with the corrected temperature, then OFF2,
// SENS2 and the temperature clamp, then the corrected offset and sensitivity.
// ============================================================================
module bpt_corr import bpt_pkg::*; (
    input  logic    i_clk,
    input  t_stg_en i_en,
    input  t_front  i_front,
    output t_corr   o_res
);

    // Stage 4: squares; A < 0 means below 20.00 C, B < 0 below -15.00 C.
    logic signed [2*W_A-1:0]   n_s4_aa;
    logic signed [2*W_B-1:0]   n_s4_bb;
    logic        [W_TEMP-1:0]  w_t2_sub;
    logic signed [W_TEMP-1:0]  n_s4_temp;
    logic        [W_SQ-1:0]    r_s4_aa;
    logic        [W_SQ-1:0]    r_s4_bb;
    logic                      r_s4_low;
    logic                      r_s4_vlow;
    logic signed [W_TEMP-1:0]  r_s4_temp;
    logic signed [W_OFF1-1:0]  r_s4_off;
    logic signed [W_SENS1-1:0] r_s4_sens;
    logic        [W_RAW-1:0]   r_s4_d1;

    assign n_s4_aa   = (2*W_A)'(i_front.a) * (2*W_A)'(i_front.a);
    assign n_s4_bb   = (2*W_B)'(i_front.b) * (2*W_B)'(i_front.b);
    assign w_t2_sub  = i_front.a[W_A-1] ? {{(W_TEMP-W_T2){1'b0}}, i_front.t2} : '0;
    assign n_s4_temp = W_TEMP'(i_front.a) + W_TEMP'(TEMP_BASE) - $signed(w_t2_sub);

    always_ff @(posedge i_clk) begin
        if (i_en.s0) begin
            r_s4_aa   <= n_s4_aa[W_SQ-1:0];
            r_s4_bb   <= n_s4_bb[W_SQ-1:0];
            r_s4_low  <= i_front.a[W_A-1];
            r_s4_vlow <= i_front.b[W_B-1];
            r_s4_temp <= n_s4_temp;
            r_s4_off  <= i_front.off;
            r_s4_sens <= i_front.sens;
            r_s4_d1   <= i_front.d1;
        end
    end

    // Stage 5: OFF2 and SENS2, both zero at or above 20.00 C.
    logic        [W_M61-1:0]   w_m61;
    logic        [W_OFF2-1:0]  w_m15;
    logic        [W_SENS2-1:0] w_m8;
    logic        [W_OFF2-1:0]  n_s5_off2;
    logic        [W_SENS2-1:0] n_s5_sens2;
    logic signed [W_TEMP-1:0]  n_s5_temp;
    logic        [W_OFF2-1:0]  r_s5_off2;
    logic        [W_SENS2-1:0] r_s5_sens2;
    logic signed [W_TEMP-1:0]  r_s5_temp;
    logic signed [W_OFF1-1:0]  r_s5_off;
    logic signed [W_SENS1-1:0] r_s5_sens;
    logic        [W_RAW-1:0]   r_s5_d1;

    assign w_m61 = W_M61'(r_s4_aa) * W_M61'(OFF2_A_MUL);
    assign w_m15 = r_s4_vlow ? W_OFF2'(r_s4_bb) * W_OFF2'(OFF2_B_MUL) : '0;
    assign w_m8  = r_s4_vlow ? W_SENS2'(r_s4_bb) * W_SENS2'(SENS2_B_MUL) : '0;

    always_comb begin
        if (r_s4_low) begin
            n_s5_off2  = W_OFF2'(w_m61[W_M61-1:OFF2_A_SH]) + w_m15;
            n_s5_sens2 = W_SENS2'(r_s4_aa) * W_SENS2'(SENS2_A_MUL) + w_m8;
        end else begin
            n_s5_off2  = '0;
            n_s5_sens2 = '0;
        end
        if (r_s4_temp < TEMP_SAT_LO) begin
            n_s5_temp = TEMP_SAT_LO;
        end else if (r_s4_temp > TEMP_SAT_HI) begin
            n_s5_temp = TEMP_SAT_HI;
        end else begin
            n_s5_temp = r_s4_temp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_s5_off2  <= n_s5_off2;
            r_s5_sens2 <= n_s5_sens2;
            r_s5_temp  <= n_s5_temp;
            r_s5_off   <= r_s4_off;
            r_s5_sens  <= r_s4_sens;
            r_s5_d1    <= r_s4_d1;
        end
    end

    // Stage 6: OFF -= OFF2, SENS -= SENS2
    t_corr n_s6;
    t_corr r_s6;

    always_comb begin
        n_s6.temp = r_s5_temp;
        n_s6.off  = W_OFF'(r_s5_off)
                  - $signed({{(W_OFF-W_OFF2){1'b0}}, r_s5_off2});
        n_s6.sens = W_SENS'(r_s5_sens)
                  - $signed({{(W_SENS-W_SENS2){1'b0}}, r_s5_sens2});
        n_s6.d1   = r_s5_d1;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_s6 <= n_s6;
        end
    end

    assign o_res = r_s6;

endmodule

### src/bpt_press.sv
// ============================================================================
// bpt_press: pressure evaluation
// Stages 7-9: D1*SENS as two partial products, their sum, then the shifts
// and the offset subtraction that give the pressure in pascals.
// ============================================================================
module bpt_press import bpt_pkg::*; (
    input  logic                     i_clk,
    input  t_stg_en                  i_en,
    input  t_corr                    i_corr,
    output logic signed [W_TEMP-1:0] o_temp,
    output logic signed [W_PRES-1:0] o_pres
);

    // Stage 7: SENS is split into an unsigned low part and a signed high part.
    logic        [W_SPLIT-1:0]        w_lo;
    logic signed [W_SENS-W_SPLIT-1:0] w_hi;
    logic        [W_PL-1:0]           n_s7_pl;
    logic signed [W_PH-1:0]           n_s7_ph;
    logic        [W_PL-1:0]           r_s7_pl;
    logic signed [W_PH-1:0]           r_s7_ph;
    logic signed [W_OFF-1:0]          r_s7_off;
    logic signed [W_TEMP-1:0]         r_s7_temp;

    assign w_lo    = i_corr.sens[W_SPLIT-1:0];
    assign w_hi    = $signed(i_corr.sens[W_SENS-1:W_SPLIT]);
    assign n_s7_pl = W_PL'(i_corr.d1) * W_PL'(w_lo);
    assign n_s7_ph = W_PH'($signed({1'b0, i_corr.d1})) * W_PH'(w_hi);

    always_ff @(posedge i_clk) begin
        if (i_en.s0) begin
            r_s7_pl   <= n_s7_pl;
            r_s7_ph   <= n_s7_ph;
            r_s7_off  <= i_corr.off;
            r_s7_temp <= i_corr.temp;
        end
    end

    // Stage 8: full product; |D1*SENS| stays below 2^63.
    logic signed [W_PROD-1:0] n_s8_prod;
    logic signed [W_PROD-1:0] r_s8_prod;
    logic signed [W_OFF-1:0]  r_s8_off;
    logic signed [W_TEMP-1:0] r_s8_temp;

    assign n_s8_prod = $signed({r_s7_ph[W_PROD-W_SPLIT-1:0], {W_SPLIT{1'b0}}})
                     + $signed({{(W_PROD-W_PL){1'b0}}, r_s7_pl});

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_s8_prod <= n_s8_prod;
            r_s8_off  <= r_s7_off;
            r_s8_temp <= r_s7_temp;
        end
    end

    // Stage 9: P = ((prod >> 21) - OFF) >> 15. The result spans fewer than
    // 32 bits for every input, so the signed 32-bit limit is never reached
    // and sign extension is the saturation.
    logic signed [W_Q-1:0]    w_q;
    logic signed [W_PRES-1:0] n_s9_pres;
    logic signed [W_PRES-1:0] r_s9_pres;
    logic signed [W_TEMP-1:0] r_s9_temp;

    assign w_q       = W_Q'($signed(r_s8_prod[W_PROD-1:PROD_SHIFT])) - W_Q'(r_s8_off);
    assign n_s9_pres = W_PRES'($signed(w_q[W_Q-1:P_SHIFT]));

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_s9_pres <= n_s9_pres;
            r_s9_temp <= r_s8_temp;
        end
    end

    assign o_temp = r_s9_temp;
    assign o_pres = r_s9_pres;

endmodule

### src/bpt_checker.sv
// ============================================================================
// bpt_checker: port-level checks of the compensation pipeline
// Watches the top-level ports only; attached to the top level by bind.
// ============================================================================
module bpt_checker import bpt_pkg::*; (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     o_in_stall,
    input logic                     o_out_valid,
    input logic                     i_out_stall,
    input logic signed [W_TEMP-1:0] o_temp_centi_c
);

    // A stalled result word stays valid.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result word dropped while stalled");

    // The pipeline never backs up into the input while the last stage is empty.
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with an empty output stage");

    // Every delivered temperature lies in the saturated range.
    a_temp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_temp_centi_c >= TEMP_SAT_LO) && (o_temp_centi_c <= TEMP_SAT_HI))
        else $error("temperature outside its saturated range");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result word valid right after reset");

endmodule

bind baro_pressure_temp_compensation bpt_checker u_bpt_checker (.*);
